// File: rtl/hps_pkg.sv
package hps_pkg;

  localparam int MAX_PEAKS         = 32;
  localparam int NUM_HARMONICS     = 20;
  localparam int GAUSS_TABLE_DEPTH = 2048;

  localparam int FREQ_W   = 20;
  localparam int INDEX_W  = 5;
  localparam int SCORE_W  = 22;
  localparam int GAUSS_W  = 17;
  localparam int CNT_W    = $clog2(MAX_PEAKS + 1);
  localparam int ADDR_W   = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int H_W      = $clog2(NUM_HARMONICS + 1);
  localparam int HARM_W   = FREQ_W + $clog2(NUM_HARMONICS + 1);
  localparam int GIDX_W   = $clog2(GAUSS_TABLE_DEPTH);
  localparam int SUM_W    = $clog2(NUM_HARMONICS * MAX_PEAKS * 65536 + NUM_HARMONICS) + 1;
  localparam int RECIP_SH = 32;
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << RECIP_SH) + NUM_HARMONICS - 1) / NUM_HARMONICS;
  localparam int RECIP_W  = $clog2(DIV_RECIP + 1);
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              present;
    logic              is_last;
  } peak_t;

  typedef struct packed {
    logic [INDEX_W-1:0] peak_index;
    logic               scored;
    logic [SCORE_W-1:0] score;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic              present;
    logic [FREQ_W-1:0] frequency;
  } entry_t;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd;
    logic [ADDR_W-1:0] rd_addr;
    logic              acc_issue;
    logic              harm_step;
    logic              load_fp;
    logic              div_start;
    logic              res_load;
    logic [CNT_W-1:0]  res_idx;
    logic              res_last;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic fp_present;
    logic div_busy;
  } status_t;

  typedef logic [GAUSS_W-1:0] gauss_rom_t [GAUSS_TABLE_DEPTH];

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((a >> i) & 64'd1);
      if (r >= b) begin
        r = r - b;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  function automatic gauss_rom_t build_gauss_rom();
    gauss_rom_t        rom;
    longint unsigned   d2;
    longint unsigned   y;
    longint unsigned   acc;
    longint unsigned   term;
    for (int d = 0; d < GAUSS_TABLE_DEPTH; d++) begin
      d2 = longint'(d) * longint'(d);
      if (d2 >= 64'd2560000) begin
        rom[d] = '0;
      end else begin
        y    = (d2 << 31) / 64'd5120000;
        acc  = 64'd2147483648;
        term = 64'd2147483648;
        for (int n = 1; n <= 12; n++) begin
          term = udiv64((term * y) >> 31, longint'(n));
          if (n % 2 == 1) acc = acc - term;
          else            acc = acc + term;
        end
        for (int i = 0; i < 5; i++) acc = (acc * acc) >> 31;
        rom[d] = GAUSS_W'((acc * 64'd65536 + 64'd1073741824) >> 31);
      end
    end
    return rom;
  endfunction

  localparam gauss_rom_t GAUSS_ROM = build_gauss_rom();

endpackage

// File: rtl/harmonic_peak_scorer_core.sv
// Channel  | Handshake                  | Payload
// peak     | peak_valid / peak_ready    | peak_data   (hps_pkg::peak_t)
// result   | result_valid / result_ready| result_data (hps_pkg::result_t)
//
// A request without is_last is stored while fewer than MAX_PEAKS are held.
// The request with is_last starts scoring; each present peak is then fetched,
// swept against every stored peak for each of NUM_HARMONICS harmonics through
// the single gaussian accumulate pipeline, drained, divided by a reciprocal
// multiply and output. An absent peak is fetched and output with a zero score.
// Synchronous active-high reset empties the set; the peak store needs no clear.
// No request is taken while a set is being scored; a stalled result holds.
module harmonic_peak_scorer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             peak_valid,
  output logic             peak_ready,
  input  hps_pkg::peak_t   peak_data,
  output logic             result_valid,
  input  logic             result_ready,
  output hps_pkg::result_t result_data
);

  hps_pkg::cmd_t    cmd;
  hps_pkg::status_t st;

  // sequence the set: load, per-peak sweep, divide, deliver
  hps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .peak_valid   (peak_valid),
    .peak_ready   (peak_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .st           (st),
    .cmd          (cmd)
  );

  // hold the store, gaussian ROM, accumulator and divider
  hps_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .peak_data   (peak_data),
    .cmd         (cmd),
    .st          (st),
    .result_data (result_data)
  );

  // never take a request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(peak_ready && result_valid))
    else $error("request taken while a result is pending");

  // absent peaks carry a zero score
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_data.scored) |-> (result_data.score == '0))
    else $error("absent peak with non-zero score");

  // after the final result the block returns to loading
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result_data.last_result) |=> peak_ready)
    else $error("block not ready after final result");

endmodule

// File: rtl/hps_datapath.sv
module hps_datapath (
  input  logic            clk,
  input  logic            rst,
  input  hps_pkg::peak_t  peak_data,
  input  hps_pkg::cmd_t   cmd,
  output hps_pkg::status_t st,
  output hps_pkg::result_t result_data
);

  hps_pkg::entry_t store [hps_pkg::MAX_PEAKS];
  hps_pkg::entry_t entry_q;

  logic [hps_pkg::FREQ_W-1:0]  fp;
  logic                        fp_pres;
  logic [hps_pkg::HARM_W-1:0]  harm;
  logic [hps_pkg::HARM_W-1:0]  harm_b;
  logic                        vld_b;
  logic [hps_pkg::HARM_W-1:0]  diff;
  logic                        hit;
  logic [hps_pkg::GIDX_W-1:0]  gidx_c;
  logic                        hit_c;
  logic [hps_pkg::GAUSS_W-1:0] g_d;
  logic                        hit_d;
  logic [hps_pkg::SUM_W-1:0]   sum;
  logic [hps_pkg::SUM_W-1:0]   div_in;
  logic [hps_pkg::SUM_W+hps_pkg::RECIP_W-1:0] prod;
  logic [hps_pkg::SUM_W-1:0]   num;
  logic                        busy;

  // store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) store[cmd.wr_addr] <= {peak_data.present, peak_data.frequency};
    if (cmd.rd) entry_q <= store[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
      hit_c <= 1'b0;
      hit_d <= 1'b0;
    end else begin
      vld_b <= cmd.acc_issue;
      hit_c <= hit;
      hit_d <= hit_c;
    end
  end

  always_comb begin
    diff = (harm_b >= hps_pkg::HARM_W'(entry_q.frequency))
         ? harm_b - hps_pkg::HARM_W'(entry_q.frequency)
         : hps_pkg::HARM_W'(entry_q.frequency) - harm_b;
    hit  = vld_b && entry_q.present &&
           (diff < hps_pkg::HARM_W'(hps_pkg::GAUSS_TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fp) begin
      fp      <= entry_q.frequency;
      fp_pres <= entry_q.present;
      harm    <= hps_pkg::HARM_W'(entry_q.frequency);
    end else if (cmd.harm_step) begin
      harm <= harm + hps_pkg::HARM_W'(fp);
    end
    if (cmd.acc_issue) harm_b <= harm;
    gidx_c <= diff[hps_pkg::GIDX_W-1:0];
    g_d    <= hps_pkg::GAUSS_ROM[gidx_c];
    if (cmd.load_fp)  sum <= '0;
    else if (hit_d)   sum <= sum + hps_pkg::SUM_W'(g_d);
  end

  // reciprocal multiply: (sum + NH/2) / NUM_HARMONICS; div_in and num are registered
  assign prod = (hps_pkg::SUM_W+hps_pkg::RECIP_W)'(div_in)
              * (hps_pkg::SUM_W+hps_pkg::RECIP_W)'(hps_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= cmd.div_start;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) div_in <= sum + hps_pkg::SUM_W'(hps_pkg::NUM_HARMONICS / 2);
    if (busy)          num    <= hps_pkg::SUM_W'(prod >> hps_pkg::RECIP_SH);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result_data.peak_index  <= hps_pkg::INDEX_W'(cmd.res_idx);
      result_data.scored      <= fp_pres;
      result_data.last_result <= cmd.res_last;
      if (!fp_pres)
        result_data.score <= '0;
      else if (num > hps_pkg::SUM_W'(hps_pkg::SCORE_MAX))
        result_data.score <= hps_pkg::SCORE_MAX;
      else
        result_data.score <= hps_pkg::SCORE_W'(num);
    end
  end

  assign st.in_last    = peak_data.is_last;
  assign st.fp_present = fp_pres;
  assign st.div_busy   = busy;

endmodule

// File: rtl/hps_ctrl.sv
module hps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             peak_valid,
  output logic             peak_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  hps_pkg::status_t st,
  output hps_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_LATCH, S_CHECK, S_RUN, S_DRAIN, S_DIV_GO, S_DIV, S_OUT
  } state_t;

  state_t                  state;
  logic [hps_pkg::CNT_W-1:0] count;
  logic [hps_pkg::CNT_W-1:0] p;
  logic [hps_pkg::CNT_W-1:0] s;
  logic [hps_pkg::H_W-1:0]   h;
  logic                      take;
  logic                      s_end;
  logic                      full;

  assign peak_ready   = (state == S_IDLE);
  assign result_valid = (state == S_OUT);
  assign take  = peak_valid && peak_ready;
  assign full  = (count == hps_pkg::CNT_W'(hps_pkg::MAX_PEAKS));
  assign s_end = (s == count - 1'b1);

  always_comb begin
    cmd           = '0;
    cmd.wr        = take && !full;
    cmd.wr_addr   = count[hps_pkg::ADDR_W-1:0];
    cmd.rd        = (state == S_FETCH) || (state == S_RUN);
    cmd.rd_addr   = (state == S_FETCH) ? p[hps_pkg::ADDR_W-1:0] : s[hps_pkg::ADDR_W-1:0];
    cmd.acc_issue = (state == S_RUN);
    cmd.harm_step = (state == S_RUN) && s_end;
    cmd.load_fp   = (state == S_LATCH);
    cmd.div_start = (state == S_DIV_GO);
    cmd.res_load  = ((state == S_CHECK) && !st.fp_present) || ((state == S_DIV) && !st.div_busy);
    cmd.res_idx   = p;
    cmd.res_last  = (p == count - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      p     <= '0;
      s     <= '0;
      h     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            if (!full) count <= count + 1'b1;
            if (st.in_last) begin
              p     <= '0;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: state <= S_LATCH;
        S_LATCH: state <= S_CHECK;
        S_CHECK: begin
          s <= '0;
          h <= hps_pkg::H_W'(1);
          state <= st.fp_present ? S_RUN : S_OUT;
        end
        S_RUN: begin
          if (s_end) begin
            s <= '0;
            if (h == hps_pkg::H_W'(hps_pkg::NUM_HARMONICS)) state <= S_DRAIN;
            else h <= h + 1'b1;
          end else begin
            s <= s + 1'b1;
          end
        end
        S_DRAIN: begin
          // let the three pipeline stages empty into the sum
          if (s == hps_pkg::CNT_W'(2)) state <= S_DIV_GO;
          else s <= s + 1'b1;
        end
        S_DIV_GO: state <= S_DIV;
        S_DIV: if (!st.div_busy) state <= S_OUT;
        S_OUT: begin
          if (result_ready) begin
            if (p == count - 1'b1) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              p     <= p + 1'b1;
              state <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
